// ===== rtl/bitmap_slab_allocator_top_assert.svh =====
// assertion macros for the bitmap slab allocator
// used by bitmap_slab_allocator_top; expects clk and rst_n in scope
`ifndef BITMAP_SLAB_ALLOCATOR_TOP_ASSERT_SVH
`define BITMAP_SLAB_ALLOCATOR_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BSA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bsa: same-cycle check failed");
`define BSA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bsa: next-cycle check failed");
`else
`define BSA_ASSERT_IMP(lbl, ante, cons)
`define BSA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/bsa_pkg.sv =====
// shared types, codes and defaults for the bitmap slab allocator
// no dependencies
`timescale 1ns / 1ps
package bsa_pkg;

  localparam int MAX_SLOTS_DEF    = 16;
  localparam int PAGE_BYTES_DEF   = 4096;
  localparam int BITMAP_BYTES_DEF = 512;

  localparam int OBJ_SIZE_W = 12;
  localparam int SLOTS_W    = 5;
  localparam int SLOT_W     = 4;
  localparam int INDEX_W    = 12;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int DVS_W      = 15;

  localparam int COUNT_MAX   = 4095;
  localparam int SIZE_RESET  = 32;
  localparam int SLOTS_RESET = 16;

  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t STATUS_OK       = 2'd0;
  localparam status_t STATUS_FULL     = 2'd1;
  localparam status_t STATUS_BAD_FREE = 2'd2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_OBJECT_SIZE  = 1'b0;
  localparam cfg_idx_t CFG_SLOTS_IN_USE = 1'b1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  function automatic logic [2:0] highest_bit(input logic [7:0] v);
    logic [2:0] r;
    r = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) begin
        r = 3'(i);
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/bitmap_slab_allocator_top.sv =====
// bitmap slab allocator top, depends on bsa_pkg and bitmap_slab_allocator_top_assert.svh
// free: read the bitmap byte, then check and set the bit, or reject at once; allocate: read and check
// each slot's free count, then each bitmap byte, with a fill of every bitmap byte (objects/8 rounded up) for a new slot
// one request at a time, the next taken in the cycle its result is strobed; no output stall
// reset (and an object_size write) runs a serial divide, then fills slot 0 one bitmap byte a cycle;
// busy stays high for that time
`timescale 1ns / 1ps
`include "bitmap_slab_allocator_top_assert.svh"
module bitmap_slab_allocator_top #(
  parameter int MAX_SLOTS    = bsa_pkg::MAX_SLOTS_DEF,
  parameter int PAGE_BYTES   = bsa_pkg::PAGE_BYTES_DEF,
  parameter int BITMAP_BYTES = bsa_pkg::BITMAP_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_op,
  input  logic [bsa_pkg::SLOT_W-1:0]    in_page_slot,
  input  logic [bsa_pkg::INDEX_W-1:0]   in_object_index,
  output logic                          out_valid,
  output bsa_pkg::status_t              out_status,
  output logic [bsa_pkg::SLOT_W-1:0]    out_slot_out,
  output logic [bsa_pkg::INDEX_W-1:0]   out_index_out,
  output logic [bsa_pkg::INDEX_W-1:0]   out_byte_offset,
  output logic                          out_new_page,
  input  logic                          cfg_we,
  input  bsa_pkg::cfg_idx_t             cfg_index,
  input  logic [bsa_pkg::OBJ_SIZE_W-1:0] cfg_data
);
  import bsa_pkg::*;

  localparam int SLW      = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int BW       = $clog2(BITMAP_BYTES);
  localparam int DEPTH    = MAX_SLOTS * BITMAP_BYTES;
  localparam int AW       = $clog2(DEPTH);
  localparam int LIMW     = ($clog2(MAX_SLOTS + 1) > SLOTS_W) ? $clog2(MAX_SLOTS + 1) : SLOTS_W;
  localparam int SXW      = (SLW > SLOT_W) ? SLW : SLOT_W;
  localparam int DIVIDEND = 8 * PAGE_BYTES;
  localparam int DW       = $clog2(DIVIDEND + 1);
  localparam int DCW      = $clog2(DW);
  localparam int NMAX     = (8 * BITMAP_BYTES < COUNT_MAX) ? 8 * BITMAP_BYTES : COUNT_MAX;
  localparam logic [DW-1:0] DIVIDEND_V = DW'(DIVIDEND);

  localparam logic [3:0] ST_DIV      = 4'd0;
  localparam logic [3:0] ST_FILL     = 4'd1;
  localparam logic [3:0] ST_IDLE     = 4'd2;
  localparam logic [3:0] ST_FREE_RD  = 4'd3;
  localparam logic [3:0] ST_FREE_CHK = 4'd4;
  localparam logic [3:0] ST_SLOT_RD  = 4'd5;
  localparam logic [3:0] ST_SLOT_CHK = 4'd6;
  localparam logic [3:0] ST_BYTE_RD  = 4'd7;
  localparam logic [3:0] ST_BYTE_CHK = 4'd8;
  localparam logic [3:0] ST_MUL      = 4'd9;

  // memories
  logic [7:0]         bmem [DEPTH];
  logic [INDEX_W-1:0] cmem [MAX_SLOTS];
  logic [7:0]         bm_rd_r;
  logic [INDEX_W-1:0] cnt_rd_r;
  logic               bm_we;
  logic [7:0]         bm_wdata;
  logic               cm_we;
  logic [INDEX_W-1:0] cm_wdata;
  logic [AW-1:0]      bm_addr;

  logic [3:0]            state_r, state_nxt;
  logic [OBJ_SIZE_W-1:0] size_r, size_nxt;
  logic [SLOTS_W-1:0]    slots_r, slots_nxt;
  logic [INDEX_W-1:0]    n_r, n_nxt;
  logic [DVS_W-1:0]      rem_r, rem_nxt;
  logic [DW-1:0]         q_r, q_nxt;
  logic [DCW-1:0]        dv_cnt_r, dv_cnt_nxt;
  logic [SLW-1:0]        sl_r, sl_nxt;
  logic [BW-1:0]         by_r, by_nxt;
  logic [2:0]            bit_r, bit_nxt;
  logic [SLW-1:0]        abs_r, abs_nxt;
  logic                  abs_found_r, abs_found_nxt;
  logic                  fresh_r, fresh_nxt;
  logic                  fill_alloc_r, fill_alloc_nxt;
  logic [INDEX_W-1:0]    cnt_hold_r, cnt_hold_nxt;
  logic [INDEX_W-1:0]    idx_r, idx_nxt;
  logic [MAX_SLOTS-1:0]  pres_r, pres_nxt;
  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]     out_slot_r, out_slot_nxt;
  logic [INDEX_W-1:0]    out_index_r, out_index_nxt;
  logic [INDEX_W-1:0]    out_offset_r, out_offset_nxt;
  logic                  out_new_page_r, out_new_page_nxt;

  logic [OBJ_SIZE_W-1:0] eff_size;
  logic [DVS_W-1:0]      divisor;
  logic [DVS_W:0]        trial;
  logic [LIMW-1:0]       lim;
  logic [10:0]           nbytes;
  logic [SXW-1:0]        pslot_x;
  logic                  accept;
  logic                  last_byte;
  logic                  last_slot;
  logic                  slot_absent;
  logic [SLW-1:0]        abs_sel;
  logic [2:0]            hb;
  logic [7:0]            fill_val;

  assign eff_size  = (size_r == '0) ? OBJ_SIZE_W'(1) : size_r;
  assign divisor   = {eff_size, 3'b000} + DVS_W'(1);
  assign trial     = {rem_r, DIVIDEND_V[dv_cnt_r]};
  assign lim       = (LIMW'(slots_r) > LIMW'(MAX_SLOTS)) ? LIMW'(MAX_SLOTS) : LIMW'(slots_r);
  assign nbytes    = 11'(({1'b0, n_r} + 13'd7) >> 3);
  assign pslot_x   = SXW'(in_page_slot);
  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign last_byte = ((11'(by_r) + 11'd1) >= nbytes);
  assign last_slot = ((32'(sl_r) + 32'd1) >= 32'(lim));
  assign slot_absent = !pres_r[sl_r];
  assign abs_sel   = (!abs_found_r && slot_absent) ? sl_r : abs_r;
  assign hb        = highest_bit(bm_rd_r);
  assign fill_val  = (32'(by_r) < 32'(n_r >> 3)) ? 8'hFF : 8'(~(8'hFF << n_r[2:0]));
  assign bm_addr   = AW'(sl_r) * AW'(BITMAP_BYTES) + AW'(by_r);

  always_comb begin
    state_nxt        = state_r;
    size_nxt         = size_r;
    slots_nxt        = slots_r;
    n_nxt            = n_r;
    rem_nxt          = rem_r;
    q_nxt            = q_r;
    dv_cnt_nxt       = dv_cnt_r;
    sl_nxt           = sl_r;
    by_nxt           = by_r;
    bit_nxt          = bit_r;
    abs_nxt          = abs_r;
    abs_found_nxt    = abs_found_r;
    fresh_nxt        = fresh_r;
    fill_alloc_nxt   = fill_alloc_r;
    cnt_hold_nxt     = cnt_hold_r;
    idx_nxt          = idx_r;
    pres_nxt         = pres_r;
    out_valid_nxt    = 1'b0;
    out_status_nxt   = out_status_r;
    out_slot_nxt     = out_slot_r;
    out_index_nxt    = out_index_r;
    out_offset_nxt   = out_offset_r;
    out_new_page_nxt = out_new_page_r;
    bm_we            = 1'b0;
    bm_wdata         = fill_val;
    cm_we            = 1'b0;
    cm_wdata         = n_r;

    case (state_r)
      ST_DIV: begin
        if (trial >= {1'b0, divisor}) begin
          rem_nxt = DVS_W'(trial - {1'b0, divisor});
          q_nxt   = {q_r[DW-2:0], 1'b1};
        end else begin
          rem_nxt = DVS_W'(trial);
          q_nxt   = {q_r[DW-2:0], 1'b0};
        end
        if (dv_cnt_r == '0) begin
          n_nxt          = (32'(q_nxt) > 32'(NMAX)) ? INDEX_W'(NMAX) : INDEX_W'(q_nxt);
          sl_nxt         = '0;
          by_nxt         = '0;
          fill_alloc_nxt = 1'b0;
          state_nxt      = (n_nxt == '0) ? ST_IDLE : ST_FILL;
        end else begin
          dv_cnt_nxt = dv_cnt_r - DCW'(1);
        end
      end
      ST_FILL: begin
        bm_we    = 1'b1;
        bm_wdata = fill_val;
        cm_we    = 1'b1;
        cm_wdata = n_r;
        if (last_byte) begin
          by_nxt    = '0;
          state_nxt = fill_alloc_r ? ST_BYTE_RD : ST_IDLE;
        end else begin
          by_nxt = by_r + BW'(1);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          out_slot_nxt     = '0;
          out_index_nxt    = '0;
          out_offset_nxt   = '0;
          out_new_page_nxt = 1'b0;
          if (in_op == OP_FREE) begin
            if ((32'(in_page_slot) >= 32'(lim)) || !pres_r[pslot_x[SLW-1:0]] ||
                (in_object_index >= n_r)) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STATUS_BAD_FREE;
            end else begin
              sl_nxt    = pslot_x[SLW-1:0];
              by_nxt    = BW'(in_object_index >> 3);
              bit_nxt   = in_object_index[2:0];
              state_nxt = ST_FREE_RD;
            end
          end else begin
            if ((lim == '0) || (n_r == '0)) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STATUS_FULL;
            end else begin
              sl_nxt        = '0;
              abs_found_nxt = 1'b0;
              fresh_nxt     = 1'b0;
              state_nxt     = ST_SLOT_RD;
            end
          end
        end
      end
      ST_FREE_RD: begin
        state_nxt = ST_FREE_CHK;
      end
      ST_FREE_CHK: begin
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
        if ((bm_rd_r & (8'b1 << bit_r)) != 8'h00) begin
          out_status_nxt = STATUS_BAD_FREE;
        end else begin
          out_status_nxt = STATUS_OK;
          bm_we    = 1'b1;
          bm_wdata = bm_rd_r | (8'b1 << bit_r);
          cm_we    = 1'b1;
          cm_wdata = (cnt_rd_r < INDEX_W'(COUNT_MAX)) ? cnt_rd_r + INDEX_W'(1) : cnt_rd_r;
        end
      end
      ST_SLOT_RD: begin
        state_nxt = ST_SLOT_CHK;
      end
      ST_SLOT_CHK: begin
        if (!slot_absent && (cnt_rd_r != '0)) begin
          cnt_hold_nxt = cnt_rd_r;
          by_nxt       = '0;
          state_nxt    = ST_BYTE_RD;
        end else if (last_slot) begin
          if (abs_found_r || slot_absent) begin
            pres_nxt[abs_sel] = 1'b1;
            sl_nxt         = abs_sel;
            by_nxt         = '0;
            fresh_nxt      = 1'b1;
            fill_alloc_nxt = 1'b1;
            cnt_hold_nxt   = n_r;
            state_nxt      = ST_FILL;
          end else begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STATUS_FULL;
            state_nxt      = ST_IDLE;
          end
        end else begin
          abs_nxt       = abs_sel;
          abs_found_nxt = abs_found_r || slot_absent;
          sl_nxt        = sl_r + SLW'(1);
          state_nxt     = ST_SLOT_RD;
        end
      end
      ST_BYTE_RD: begin
        state_nxt = ST_BYTE_CHK;
      end
      ST_BYTE_CHK: begin
        if (bm_rd_r != 8'h00) begin
          bm_we     = 1'b1;
          bm_wdata  = bm_rd_r & ~(8'b1 << hb);
          cm_we     = 1'b1;
          cm_wdata  = (cnt_hold_r != '0) ? cnt_hold_r - INDEX_W'(1) : cnt_hold_r;
          idx_nxt   = INDEX_W'({by_r, hb});
          state_nxt = ST_MUL;
        end else if (last_byte) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STATUS_FULL;
          state_nxt      = ST_IDLE;
        end else begin
          by_nxt    = by_r + BW'(1);
          state_nxt = ST_BYTE_RD;
        end
      end
      ST_MUL: begin
        out_valid_nxt    = 1'b1;
        out_status_nxt   = STATUS_OK;
        out_slot_nxt     = SLOT_W'(sl_r);
        out_index_nxt    = idx_r;
        out_offset_nxt   = INDEX_W'(idx_r * eff_size);
        out_new_page_nxt = fresh_r;
        state_nxt        = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_we) begin
      if (cfg_index == CFG_OBJECT_SIZE) begin
        size_nxt     = cfg_data;
        pres_nxt     = MAX_SLOTS'(1);
        rem_nxt      = '0;
        q_nxt        = '0;
        dv_cnt_nxt   = DCW'(DW - 1);
        state_nxt    = ST_DIV;
      end else if (cfg_index == CFG_SLOTS_IN_USE) begin
        slots_nxt = cfg_data[SLOTS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_DIV;
      size_r      <= OBJ_SIZE_W'(SIZE_RESET);
      slots_r     <= SLOTS_W'(SLOTS_RESET);
      pres_r      <= MAX_SLOTS'(1);
      rem_r       <= '0;
      q_r         <= '0;
      dv_cnt_r    <= DCW'(DW - 1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      size_r      <= size_nxt;
      slots_r     <= slots_nxt;
      pres_r      <= pres_nxt;
      rem_r       <= rem_nxt;
      q_r         <= q_nxt;
      dv_cnt_r    <= dv_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r            <= n_nxt;
    sl_r           <= sl_nxt;
    by_r           <= by_nxt;
    bit_r          <= bit_nxt;
    abs_r          <= abs_nxt;
    abs_found_r    <= abs_found_nxt;
    fresh_r        <= fresh_nxt;
    fill_alloc_r   <= fill_alloc_nxt;
    cnt_hold_r     <= cnt_hold_nxt;
    idx_r          <= idx_nxt;
    out_status_r   <= out_status_nxt;
    out_slot_r     <= out_slot_nxt;
    out_index_r    <= out_index_nxt;
    out_offset_r   <= out_offset_nxt;
    out_new_page_r <= out_new_page_nxt;
  end

  // bitmap store, one byte per entry
  always_ff @(posedge clk) begin
    if (bm_we) begin
      bmem[bm_addr] <= bm_wdata;
    end
    bm_rd_r <= bmem[bm_addr];
  end

  // free counts per slot
  always_ff @(posedge clk) begin
    if (cm_we) begin
      cmem[sl_r] <= cm_wdata;
    end
    cnt_rd_r <= cmem[sl_r];
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_slot_out    = out_slot_r;
  assign out_index_out   = out_index_r;
  assign out_byte_offset = out_offset_r;
  assign out_new_page    = out_new_page_r;

  `BSA_ASSERT_IMP(a_fields_clear, out_valid && (out_status != STATUS_OK), (out_slot_out == '0) && (out_index_out == '0) && (out_byte_offset == '0) && !out_new_page)
  `BSA_ASSERT_NEXT(a_accept_progress, accept, busy || out_valid)
  `BSA_ASSERT_IMP(a_new_page_index, out_valid && out_new_page, (n_r >= INDEX_W'(8)) ? (out_index_out == INDEX_W'(7)) : (out_index_out == n_r - INDEX_W'(1)))

endmodule

// ===== tb/tb.sv =====
// testbench for bitmap_slab_allocator_top: directed and random allocate/free requests
// a scoreboard class predicts every result; depends on bsa_pkg and the allocator rtl
`timescale 1ns / 1ps
module tb;
  import bsa_pkg::*;

  typedef struct packed {
    status_t              status;
    logic [SLOT_W-1:0]    slot;
    logic [INDEX_W-1:0]   obj_index;
    logic [INDEX_W-1:0]   offset;
    logic                 fresh;
  } slab_result_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [INDEX_W-1:0] obj_index;
  } obj_ref_t;

  class slab_tracker;
    bit           present [MAX_SLOTS_DEF];
    int unsigned  free_cnt [MAX_SLOTS_DEF];
    bit [7:0]     bitmap [MAX_SLOTS_DEF][BITMAP_BYTES_DEF];
    int unsigned  size_setting;
    int unsigned  slot_cap;
    slab_result_t pending_results [$];
    int           errors;

    function new();
      errors = 0;
      size_setting = SIZE_RESET;
      slot_cap = SLOTS_RESET;
      restart();
    endfunction

    function int unsigned eff_size();
      return (size_setting == 0) ? 1 : size_setting;
    endfunction

    function int unsigned per_page();
      int unsigned n;
      n = (8 * PAGE_BYTES_DEF) / (8 * eff_size() + 1);
      if (n > 8 * BITMAP_BYTES_DEF) n = 8 * BITMAP_BYTES_DEF;
      if (n > COUNT_MAX) n = COUNT_MAX;
      return n;
    endfunction

    function int unsigned slot_limit();
      return (slot_cap > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF : slot_cap;
    endfunction

    function void fill_slot(int unsigned s, int unsigned n);
      for (int b = 0; b < BITMAP_BYTES_DEF; b++) begin
        if (b < n / 8) begin
          bitmap[s][b] = 8'hFF;
        end else if (b == n / 8 && (n % 8) != 0) begin
          bitmap[s][b] = 8'((1 << (n % 8)) - 1);
        end else begin
          bitmap[s][b] = 8'h00;
        end
      end
      free_cnt[s] = n;
    endfunction

    function void restart();
      int unsigned n;
      n = per_page();
      for (int s = 0; s < MAX_SLOTS_DEF; s++) begin
        present[s] = 1'b0;
        free_cnt[s] = n;
        for (int b = 0; b < BITMAP_BYTES_DEF; b++) begin
          bitmap[s][b] = 8'h00;
        end
      end
      present[0] = 1'b1;
      fill_slot(0, n);
    endfunction

    function void write_reg(cfg_idx_t idx, logic [OBJ_SIZE_W-1:0] d);
      if (idx == CFG_OBJECT_SIZE) begin
        size_setting = d;
        restart();
      end else begin
        slot_cap = d[SLOTS_W-1:0];
      end
    endfunction

    function slab_result_t note_request(logic op, logic [SLOT_W-1:0] ps,
                                        logic [INDEX_W-1:0] oi);
      slab_result_t r;
      int unsigned  n;
      int unsigned  lim;
      int unsigned  nbytes;
      int unsigned  s;
      int unsigned  b;
      int unsigned  bt;
      int unsigned  idx;
      bit           fresh;
      r = '0;
      n = per_page();
      lim = slot_limit();
      nbytes = (n + 7) / 8;
      fresh = 1'b0;
      if (op == OP_FREE) begin
        if (ps >= lim || !present[ps] || oi >= n || bitmap[ps][oi / 8][oi % 8]) begin
          r.status = STATUS_BAD_FREE;
        end else begin
          bitmap[ps][oi / 8][oi % 8] = 1'b1;
          if (free_cnt[ps] < COUNT_MAX) free_cnt[ps]++;
        end
      end else if (n == 0) begin
        r.status = STATUS_FULL;
      end else begin
        s = lim;
        for (int i = 0; i < lim; i++) begin
          if (s == lim && present[i] && free_cnt[i] > 0) s = i;
        end
        if (s == lim) begin
          for (int i = 0; i < lim; i++) begin
            if (s == lim && !present[i]) s = i;
          end
          if (s != lim) begin
            present[s] = 1'b1;
            fill_slot(s, n);
            fresh = 1'b1;
          end
        end
        if (s == lim) begin
          r.status = STATUS_FULL;
        end else begin
          b = nbytes;
          for (int i = 0; i < nbytes; i++) begin
            if (b == nbytes && bitmap[s][i] != 8'h00) b = i;
          end
          if (b == nbytes) begin
            r.status = STATUS_FULL;
          end else begin
            bt = 7;
            while (!bitmap[s][b][bt]) bt--;
            bitmap[s][b][bt] = 1'b0;
            if (free_cnt[s] > 0) free_cnt[s]--;
            idx = b * 8 + bt;
            r.status = STATUS_OK;
            r.slot = SLOT_W'(s);
            r.obj_index = INDEX_W'(idx);
            r.offset = INDEX_W'(idx * eff_size());
            r.fresh = fresh;
          end
        end
      end
      pending_results.push_back(r);
      return r;
    endfunction

    function void check_result(slab_result_t got);
      slab_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with none pending: status %0d slot %0d index %0d offset %0d new_page %0d",
                 $time, got.status, got.slot, got.obj_index, got.offset, got.fresh);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.slot !== want.slot ||
            got.obj_index !== want.obj_index || got.offset !== want.offset ||
            got.fresh !== want.fresh) begin
          errors++;
          $display("%0t: expected status %0d slot %0d index %0d offset %0d new_page %0d",
                   $time, want.status, want.slot, want.obj_index, want.offset, want.fresh);
          $display("%0t:   actual status %0d slot %0d index %0d offset %0d new_page %0d",
                   $time, got.status, got.slot, got.obj_index, got.offset, got.fresh);
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  in_op = OP_ALLOC;
  logic [SLOT_W-1:0]     in_page_slot = '0;
  logic [INDEX_W-1:0]    in_object_index = '0;
  logic                  out_valid;
  status_t               out_status;
  logic [SLOT_W-1:0]     out_slot_out;
  logic [INDEX_W-1:0]    out_index_out;
  logic [INDEX_W-1:0]    out_byte_offset;
  logic                  out_new_page;
  logic                  cfg_we = 1'b0;
  cfg_idx_t              cfg_index = CFG_OBJECT_SIZE;
  logic [OBJ_SIZE_W-1:0] cfg_data = '0;

  slab_tracker sb;
  obj_ref_t    live_objs [$];
  obj_ref_t    last_freed = '0;

  bitmap_slab_allocator_top u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_page_slot    (in_page_slot),
    .in_object_index (in_object_index),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_slot_out    (out_slot_out),
    .out_index_out   (out_index_out),
    .out_byte_offset (out_byte_offset),
    .out_new_page    (out_new_page),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #4 clk = ~clk;

  initial begin
    #50_000_000;
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      sb.check_result({out_status, out_slot_out, out_index_out, out_byte_offset, out_new_page});
    end
  end

  // start low, then wait for every result and an idle block
  task automatic settle();
    start <= 1'b0;
    do @(negedge clk); while (sb.pending_results.size() != 0 || busy !== 1'b0);
  endtask

  task automatic cfg_write(cfg_idx_t idx, logic [OBJ_SIZE_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, d);
    if (idx == CFG_OBJECT_SIZE) live_objs.delete();
    do @(negedge clk); while (busy !== 1'b0);
  endtask

  task automatic send(logic op, logic [SLOT_W-1:0] ps, logic [INDEX_W-1:0] oi);
    slab_result_t r;
    start <= 1'b1;
    in_op <= op;
    in_page_slot <= ps;
    in_object_index <= oi;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    r = sb.note_request(op, ps, oi);
    if (op == OP_ALLOC && r.status == STATUS_OK) begin
      live_objs.push_back(obj_ref_t'{r.slot, r.obj_index});
    end
    @(negedge clk);
  endtask

  task automatic pause_maybe(int pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic random_phase(int count, int alloc_pct, int gap_pct);
    int unsigned n;
    int          k;
    obj_ref_t    o;
    n = sb.per_page();
    for (int i = 0; i < count; i++) begin
      pause_maybe(gap_pct);
      if (gap_pct != 0 && $urandom_range(99) < 3) settle();
      if ($urandom_range(99) < alloc_pct) begin
        send(OP_ALLOC, SLOT_W'($urandom), INDEX_W'($urandom));
      end else if (live_objs.size() > 0 && $urandom_range(99) < 80) begin
        k = $urandom_range(live_objs.size() - 1);
        o = live_objs[k];
        live_objs.delete(k);
        last_freed = o;
        send(OP_FREE, o.slot, o.obj_index);
      end else if ($urandom_range(1) == 1) begin
        // double free of the most recently freed object
        send(OP_FREE, last_freed.slot, last_freed.obj_index);
      end else begin
        send(OP_FREE, SLOT_W'($urandom),
             ($urandom_range(1) == 1) ? INDEX_W'($urandom) : INDEX_W'($urandom_range(n + 1)));
      end
    end
  endtask

  initial begin
    int          remaining;
    int          phase;
    int          count;
    int          r;
    int unsigned sz;
    int unsigned lim;
    sb = new();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    settle();

    // directed: reset setting
    send(OP_ALLOC, '0, '0);
    send(OP_FREE, 4'd0, 12'd7);
    send(OP_FREE, 4'd0, 12'd7);
    send(OP_FREE, 4'd0, 12'd127);
    send(OP_FREE, 4'd15, 12'd4095);
    send(OP_ALLOC, 4'd15, 12'd4095);
    send(OP_ALLOC, '0, '0);
    // size zero taken as one
    settle();
    cfg_write(CFG_OBJECT_SIZE, 12'd0);
    send(OP_ALLOC, '0, '0);
    send(OP_FREE, 4'd0, 12'd3640);
    send(OP_FREE, 4'd0, 12'd3639);
    send(OP_FREE, 4'd0, 12'd7);
    // one object per page, two slots
    settle();
    cfg_write(CFG_OBJECT_SIZE, 12'd4095);
    cfg_write(CFG_SLOTS_IN_USE, 12'd2);
    send(OP_ALLOC, '0, '0);
    send(OP_ALLOC, '0, '0);
    send(OP_ALLOC, '0, '0);
    send(OP_FREE, 4'd1, 12'd0);
    send(OP_FREE, 4'd2, 12'd0);
    send(OP_ALLOC, '0, '0);
    // no slots at all
    settle();
    cfg_write(CFG_SLOTS_IN_USE, 12'd0);
    send(OP_ALLOC, '0, '0);
    send(OP_FREE, 4'd0, 12'd0);
    // limit above the slot count
    settle();
    cfg_write(CFG_SLOTS_IN_USE, 12'd31);
    send(OP_ALLOC, '0, '0);
    // limit reduced below present slots
    settle();
    cfg_write(CFG_SLOTS_IN_USE, 12'd1);
    send(OP_FREE, 4'd1, 12'd0);
    send(OP_ALLOC, '0, '0);

    remaining = 630;
    phase = 0;
    while (remaining > 0) begin
      settle();
      if (phase == 0 || $urandom_range(99) < 70) begin
        r = $urandom_range(99);
        if (r < 45) sz = $urandom_range(4095, 512);
        else if (r < 70) sz = $urandom_range(511, 64);
        else if (r < 85) sz = $urandom_range(63, 16);
        else if (r < 93) sz = $urandom_range(15, 0);
        else begin
          case ($urandom_range(3))
            0: sz = 0;
            1: sz = 1;
            2: sz = 2048;
            default: sz = 4095;
          endcase
        end
        cfg_write(CFG_OBJECT_SIZE, OBJ_SIZE_W'(sz));
      end
      if (phase == 0 || $urandom_range(99) < 60) begin
        r = $urandom_range(99);
        if (r < 10) lim = 0;
        else if (r < 25) lim = $urandom_range(31, 17);
        else if (r < 40) lim = 16;
        else lim = $urandom_range(16, 1);
        cfg_write(CFG_SLOTS_IN_USE, {7'($urandom), 5'(lim)});
      end
      if (sb.per_page() > 255) count = $urandom_range(30, 15);
      else count = $urandom_range(60, 30);
      if (count > remaining) count = remaining;
      case ($urandom_range(2))
        0: r = 80;
        1: r = 55;
        default: r = 30;
      endcase
      random_phase(count, r, (phase == 2) ? 0 : 31);
      remaining -= count;
      phase++;
    end

    settle();
    repeat (2000) @(negedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/bsa_pkg.sv
rtl/bitmap_slab_allocator_top.sv
tb/tb.sv
